// File: hw/rtl/pbc_pkg.sv
// Shared types, constants and helpers for the pileup base counter.
package pbc_pkg;

    localparam int NUM_SAMPLES  = 16;
    localparam int COUNT_BITS   = 16;
    localparam int NUM_BASES    = 4;
    localparam int QUAL_OFFSET  = 33;
    localparam int ROW_BITS     = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int NUM_OUT      = (NUM_SAMPLES < 16) ? NUM_SAMPLES : 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [15:0] FLAG_DROP_MASK = 16'h0900 | 16'h0400 | 16'h0200;
    localparam logic [3:0]  LAST_SAMPLE    = 4'(NUM_OUT - 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_START = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_END   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAPPING_CUT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUALITY_CUT  = 2'd3;

    typedef struct packed {
        logic        func;
        logic [7:0]  map_quality;
        logic [6:0]  quality_char;
        logic [15:0] align_flags;
        logic        is_deletion;
        logic        sample_known;
        logic [3:0]  sample_index;
        logic [6:0]  base_char;
        logic [31:0] site_position;
        logic [6:0]  ref_char;
    } pbc_item_t;

    typedef struct packed {
        logic        site_valid;
        logic [1:0]  ref_index;
        logic [3:0]  out_sample;
        logic [15:0] count_a;
        logic [15:0] count_c;
        logic [15:0] count_g;
        logic [15:0] count_t;
        logic        last;
    } pbc_result_t;

    typedef logic [NUM_BASES-1:0][COUNT_BITS-1:0] pbc_row_t;

    typedef struct packed {
        logic accept;
        logic write;
        logic fetch;
        logic advance;
        logic clear;
    } pbc_cmd_t;

    typedef struct packed {
        logic item_end;
        logic item_site_ok;
        logic last;
    } pbc_sts_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_FETCH,
        ST_SHOW
    } pbc_state_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] idx;
    } pbc_base_t;

    // ACGT in either case
    function automatic pbc_base_t base_code(input logic [6:0] ch);
        pbc_base_t b;
        b = '{ok: 1'b1, idx: 2'd0};
        unique case (ch)
            7'h41, 7'h61: b.idx = 2'd0;
            7'h43, 7'h63: b.idx = 2'd1;
            7'h47, 7'h67: b.idx = 2'd2;
            7'h54, 7'h74: b.idx = 2'd3;
            default:      b.ok  = 1'b0;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] report(input logic [COUNT_BITS-1:0] c);
        logic [31:0] wide;
        wide = 32'(c);
        return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
    endfunction

endpackage

// File: hw/rtl/pbc_ctrl.sv
// Sequencing state machine for the pileup base counter.
module pbc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  pbc_pkg::pbc_sts_t   sts,
    output pbc_pkg::pbc_cmd_t   cmd
);

    pbc_pkg::pbc_state_t state_reg;
    pbc_pkg::pbc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        item_stall   = 1'b1;
        result_valid = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            pbc_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!sts.item_end)
                    begin
                        state_next = pbc_pkg::ST_UPDATE;
                    end
                    else if (sts.item_site_ok)
                    begin
                        state_next = pbc_pkg::ST_FETCH;
                    end
                    else
                    begin
                        state_next = pbc_pkg::ST_SHOW;
                    end
                end
            end
            pbc_pkg::ST_UPDATE:
            begin
                cmd.write  = 1'b1;
                state_next = pbc_pkg::ST_IDLE;
            end
            pbc_pkg::ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = pbc_pkg::ST_SHOW;
            end
            pbc_pkg::ST_SHOW:
            begin
                result_valid = 1'b1;
                if (!result_stall)
                begin
                    cmd.advance = 1'b1;
                    if (sts.last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = pbc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = pbc_pkg::ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = pbc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/pbc_datapath.sv
// Config registers, read filter, counter RAM and result word for the pileup base counter.
module pbc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pbc_pkg::pbc_item_t                   item,
    input  logic                                 cfg_we,
    input  logic [pbc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pbc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  pbc_pkg::pbc_cmd_t                    cmd,
    output pbc_pkg::pbc_sts_t                    sts,
    output pbc_pkg::pbc_result_t                 result
);

    logic [31:0] region_start_reg;
    logic [31:0] region_end_reg;
    logic [7:0]  mapping_cut_reg;
    logic [6:0]  quality_cut_reg;

    logic                          keep_reg;
    logic [pbc_pkg::ROW_BITS-1:0]  row_reg;
    logic [1:0]                    base_reg;
    logic                          site_ok_reg;
    logic [1:0]                    ref_idx_reg;
    logic [3:0]                    sample_reg;
    pbc_pkg::pbc_row_t             rd_row_reg;
    logic                          rd_ok_reg;
    logic [pbc_pkg::NUM_SAMPLES-1:0] row_valid_reg;

    pbc_pkg::pbc_row_t count_ram [pbc_pkg::NUM_SAMPLES];

    pbc_pkg::pbc_base_t            read_base;
    pbc_pkg::pbc_base_t            ref_base;
    logic                          keep_next;
    logic                          site_ok_next;
    logic [7:0]                    qual_floor;
    logic [pbc_pkg::ROW_BITS-1:0]  rd_addr;
    pbc_pkg::pbc_row_t             cur_row;
    pbc_pkg::pbc_row_t             upd_row;
    logic                          is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_end_reg   <= 32'hFFFF_FFFF;
            mapping_cut_reg  <= '0;
            quality_cut_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pbc_pkg::CFG_REGION_START: region_start_reg <= cfg_data[31:0];
                pbc_pkg::CFG_REGION_END:   region_end_reg   <= cfg_data[31:0];
                pbc_pkg::CFG_MAPPING_CUT:  mapping_cut_reg  <= cfg_data[7:0];
                pbc_pkg::CFG_QUALITY_CUT:  quality_cut_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // read filter and site check on the incoming word
    always_comb
    begin
        read_base  = pbc_pkg::base_code(item.base_char);
        ref_base   = pbc_pkg::base_code(item.ref_char);
        qual_floor = {1'b0, quality_cut_reg} + 8'(pbc_pkg::QUAL_OFFSET);
        keep_next  = !item.is_deletion
                  && (item.map_quality > mapping_cut_reg)
                  && ({1'b0, item.quality_char} > qual_floor)
                  && ((item.align_flags & pbc_pkg::FLAG_DROP_MASK) == 16'h0000)
                  && item.sample_known
                  && (32'(item.sample_index) < 32'(pbc_pkg::NUM_SAMPLES))
                  && read_base.ok;
        site_ok_next = (item.site_position >= region_start_reg)
                    && (item.site_position < region_end_reg)
                    && ref_base.ok;
        rd_addr = cmd.fetch ? pbc_pkg::ROW_BITS'(sample_reg)
                            : pbc_pkg::ROW_BITS'(item.sample_index);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            keep_reg    <= keep_next;
            row_reg     <= pbc_pkg::ROW_BITS'(item.sample_index);
            base_reg    <= read_base.idx;
            site_ok_reg <= site_ok_next;
            ref_idx_reg <= ref_base.idx;
        end
        if (cmd.accept || cmd.fetch)
        begin
            rd_row_reg <= count_ram[rd_addr];
            rd_ok_reg  <= row_valid_reg[rd_addr];
        end
        if (cmd.write && keep_reg)
        begin
            count_ram[row_reg] <= upd_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg    <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                sample_reg <= '0;
            end
            else if (cmd.advance)
            begin
                sample_reg <= sample_reg + 4'd1;
            end
            if (cmd.clear)
            begin
                row_valid_reg <= '0;
            end
            else if (cmd.write && keep_reg)
            begin
                row_valid_reg[row_reg] <= 1'b1;
            end
        end
    end

    // saturating increment of the selected base
    always_comb
    begin
        cur_row = rd_ok_reg ? rd_row_reg : '0;
        upd_row = cur_row;
        for (int b = 0; b < pbc_pkg::NUM_BASES; b++)
        begin
            if ((2'(b) == base_reg) && (cur_row[b] != {pbc_pkg::COUNT_BITS{1'b1}}))
            begin
                upd_row[b] = cur_row[b] + pbc_pkg::COUNT_BITS'(1);
            end
        end
    end

    always_comb
    begin
        is_last           = !site_ok_reg || (sample_reg == pbc_pkg::LAST_SAMPLE);
        sts.item_end      = item.func;
        sts.item_site_ok  = site_ok_next;
        sts.last          = is_last;
        result.site_valid = site_ok_reg;
        result.ref_index  = site_ok_reg ? ref_idx_reg : 2'd0;
        result.out_sample = site_ok_reg ? sample_reg : 4'd0;
        result.count_a    = site_ok_reg ? pbc_pkg::report(cur_row[0]) : 16'd0;
        result.count_c    = site_ok_reg ? pbc_pkg::report(cur_row[1]) : 16'd0;
        result.count_g    = site_ok_reg ? pbc_pkg::report(cur_row[2]) : 16'd0;
        result.count_t    = site_ok_reg ? pbc_pkg::report(cur_row[3]) : 16'd0;
        result.last       = is_last;
    end

endmodule

// File: hw/rtl/pileup_base_counter.sv
// Top level of the pileup base counter: controller and datapath.
// Counts kept read bases per sample at one site in a RAM of one row per sample
// (four saturating counters a row). The row of a read word is fetched from the
// single RAM port on accept, then incremented and written back in ST_UPDATE.
// An end word in the region with an ACGT reference gives one result per sample
// in sample order, each fetched in ST_FETCH, then output in ST_SHOW (which can
// stall); any other end word gives one result marked invalid. The counters are
// cleared at once by per-row valid bits, with no clearing pass after reset or a
// site. Configuration must be written only while the block is idle (unchecked).
module pileup_base_counter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  pbc_pkg::pbc_item_t                   item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output pbc_pkg::pbc_result_t                 result,
    input  logic                                 cfg_we,
    input  logic [pbc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pbc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    pbc_pkg::pbc_cmd_t cmd;
    pbc_pkg::pbc_sts_t sts;

    pbc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    pbc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

endmodule

// File: test/testbench.sv
// Testbench of the pileup base counter: read and site-end words checked against per-sample counts.
`timescale 1ns / 100ps

module testbench;

    localparam logic FUNC_READ = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    localparam int SLOT_A  = 0;
    localparam int SLOT_C  = 1;
    localparam int SLOT_G  = 2;
    localparam int SLOT_T  = 3;
    localparam int NO_BASE = 4;

    localparam logic [6:0] CH_A  = 7'h41;
    localparam logic [6:0] CH_C  = 7'h43;
    localparam logic [6:0] CH_G  = 7'h47;
    localparam logic [6:0] CH_T  = 7'h54;
    localparam logic [6:0] CH_LA = 7'h61;
    localparam logic [6:0] CH_LC = 7'h63;
    localparam logic [6:0] CH_LG = 7'h67;
    localparam logic [6:0] CH_LT = 7'h74;
    localparam logic [6:0] CH_N  = 7'h4E;

    typedef enum int { WELL, BROKEN, NOISE } shape_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    pbc_pkg::pbc_item_t   item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    pbc_pkg::pbc_result_t result;
    logic                 cfg_we = 1'b0;
    logic [pbc_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [pbc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    pbc_pkg::pbc_item_t   pending_words[$];
    pbc_pkg::pbc_result_t site_results[$];
    pbc_pkg::pbc_result_t want;

    logic [pbc_pkg::COUNT_BITS-1:0] tally[pbc_pkg::NUM_SAMPLES][pbc_pkg::NUM_BASES];
    logic [31:0] win_lo = 32'h0;
    logic [31:0] win_hi = 32'hFFFF_FFFF;
    logic [7:0]  mq_cut = 8'h0;
    logic [6:0]  q_cut  = 7'h0;

    bit quiet = 1'b0;
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    int gap = 0;
    int pause = 0;
    int hold = 0;
    int shown = 0;
    int errors = 0;

    pileup_base_counter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void add_word(pbc_pkg::pbc_item_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic void add_result(pbc_pkg::pbc_result_t r);
        site_results.insert(site_results.size(), r);
    endfunction

    function automatic int base_slot(logic [6:0] ch);
        case (ch)
            CH_A, CH_LA: return SLOT_A;
            CH_C, CH_LC: return SLOT_C;
            CH_G, CH_LG: return SLOT_G;
            CH_T, CH_LT: return SLOT_T;
            default:     return NO_BASE;
        endcase
    endfunction

    function automatic void clear_tally();
        foreach (tally[s, b])
            tally[s][b] = '0;
    endfunction

    // Expected effect of one accepted word on the counters and the result stream
    function automatic void count_word(pbc_pkg::pbc_item_t w);
        int b;
        bit keep;
        pbc_pkg::pbc_result_t r;
        if (w.func == FUNC_READ)
        begin
            b = base_slot(w.base_char);
            keep = !w.is_deletion
                && w.map_quality > mq_cut
                && int'(w.quality_char) > int'(q_cut) + pbc_pkg::QUAL_OFFSET
                && (w.align_flags & pbc_pkg::FLAG_DROP_MASK) == 16'h0
                && w.sample_known
                && int'(w.sample_index) < pbc_pkg::NUM_SAMPLES
                && b != NO_BASE;
            if (keep && tally[w.sample_index][b] != '1)
                tally[w.sample_index][b] = tally[w.sample_index][b] + 1'b1;
        end
        else
        begin
            b = base_slot(w.ref_char);
            if (w.site_position >= win_lo && w.site_position < win_hi && b != NO_BASE)
            begin
                for (int s = 0; s < pbc_pkg::NUM_OUT; s++)
                begin
                    r.site_valid = 1'b1;
                    r.ref_index  = 2'(b);
                    r.out_sample = 4'(s);
                    r.count_a    = 16'(tally[s][SLOT_A]);
                    r.count_c    = 16'(tally[s][SLOT_C]);
                    r.count_g    = 16'(tally[s][SLOT_G]);
                    r.count_t    = 16'(tally[s][SLOT_T]);
                    r.last       = (s == pbc_pkg::NUM_OUT - 1);
                    add_result(r);
                end
            end
            else
            begin
                r = '0;
                r.last = 1'b1;
                add_result(r);
            end
            clear_tally();
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            errors++;
        end
    endfunction

    function automatic logic [6:0] pick_base();
        case ($urandom_range(0, 7))
            0: return CH_A;
            1: return CH_C;
            2: return CH_G;
            3: return CH_T;
            4: return CH_LA;
            5: return CH_LC;
            6: return CH_LG;
            default: return CH_LT;
        endcase
    endfunction

    function automatic pbc_pkg::pbc_item_t random_word();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(pbc_pkg::pbc_item_t)-1:0];
    endfunction

    function automatic pbc_pkg::pbc_item_t read_of(logic [3:0] smp, logic [6:0] ch);
        pbc_pkg::pbc_item_t w;
        w = '0;
        w.func         = FUNC_READ;
        w.map_quality  = 8'd60;
        w.quality_char = 7'd70;
        w.sample_known = 1'b1;
        w.sample_index = smp;
        w.base_char    = ch;
        return w;
    endfunction

    function automatic pbc_pkg::pbc_item_t end_of(logic [31:0] pos, logic [6:0] ch);
        pbc_pkg::pbc_item_t w;
        w = '0;
        w.func          = FUNC_END;
        w.site_position = pos;
        w.ref_char      = ch;
        return w;
    endfunction

    function automatic pbc_pkg::pbc_item_t make_read(shape_t shape);
        pbc_pkg::pbc_item_t w;
        w = random_word();
        w.func = FUNC_READ;
        if (shape == NOISE)
            return w;
        w.is_deletion  = 1'b0;
        w.sample_known = 1'b1;
        w.align_flags  = w.align_flags & ~pbc_pkg::FLAG_DROP_MASK;
        w.base_char    = pick_base();
        if ($urandom_range(0, 1))
            w.sample_index = 4'($urandom_range(0, 3));
        if (mq_cut != 8'hFF)
            w.map_quality = 8'($urandom_range(255, int'(mq_cut) + 1));
        if (int'(q_cut) + pbc_pkg::QUAL_OFFSET < 127)
            w.quality_char = 7'($urandom_range(127, int'(q_cut) + pbc_pkg::QUAL_OFFSET + 1));
        if (shape == BROKEN)
        begin
            case ($urandom_range(0, 5))
                0: w.is_deletion = 1'b1;
                1: w.map_quality = mq_cut;
                2: w.quality_char = 7'(int'(q_cut) + pbc_pkg::QUAL_OFFSET);
                3: w.align_flags[$urandom_range(8, 11)] = 1'b1;
                4: w.sample_known = 1'b0;
                default: w.base_char = 7'($urandom);
            endcase
        end
        return w;
    endfunction

    function automatic pbc_pkg::pbc_item_t make_end(bit good);
        pbc_pkg::pbc_item_t w;
        w = random_word();
        w.func = FUNC_END;
        if (good && win_lo < win_hi)
        begin
            w.ref_char = pick_base();
            case ($urandom_range(0, 3))
                0: w.site_position = win_lo;
                1: w.site_position = win_hi - 1;
                default: w.site_position = win_lo + ($urandom % (win_hi - win_lo));
            endcase
        end
        else if ($urandom_range(0, 1))
            w.site_position = win_hi;
        return w;
    endfunction

    task automatic write_regs(logic [31:0] lo, logic [31:0] hi, logic [7:0] mq, logic [6:0] q);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= pbc_pkg::CFG_REGION_START;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= pbc_pkg::CFG_REGION_END;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= pbc_pkg::CFG_MAPPING_CUT;
        cfg_data  <= 32'(mq);
        @(posedge clk);
        cfg_index <= pbc_pkg::CFG_QUALITY_CUT;
        cfg_data  <= 32'(q);
        @(posedge clk);
        cfg_we <= 1'b0;
        win_lo = lo;
        win_hi = hi;
        mq_cut = mq;
        q_cut  = q;
    endtask

    // Wait until all words are sent and all expected results have been received
    task automatic drain();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || item_valid || site_results.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            gap = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                count_word(item);
            if (!item_valid || !item_stall)
            begin
                if (gap > 0)
                begin
                    gap--;
                    item_valid <= 1'b0;
                end
                else if (!quiet && sender_idles && $urandom_range(0, 4) == 0)
                begin
                    gap = $urandom_range(0, 14);
                    item_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    item       <= pending_words.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (site_results.size() == 0)
                begin
                    $error("unexpected result word for sample %0d", result.out_sample);
                    errors++;
                end
                else
                begin
                    want = site_results.pop_front();
                    check_field("site_valid", 32'(want.site_valid), 32'(result.site_valid));
                    check_field("ref_index", 32'(want.ref_index), 32'(result.ref_index));
                    check_field("out_sample", 32'(want.out_sample), 32'(result.out_sample));
                    check_field("count_a", 32'(want.count_a), 32'(result.count_a));
                    check_field("count_c", 32'(want.count_c), 32'(result.count_c));
                    check_field("count_g", 32'(want.count_g), 32'(result.count_g));
                    check_field("count_t", 32'(want.count_t), 32'(result.count_t));
                    check_field("last", 32'(want.last), 32'(result.last));
                end
                shown++;
                if (shown == 100 && !quiet)
                    hold = 400;
            end
            if (hold > 0)
            begin
                hold--;
                result_stall <= 1'b1;
            end
            else if (pause > 0)
            begin
                pause--;
                result_stall <= 1'b1;
            end
            else if (!quiet && receiver_idles && $urandom_range(0, 4) == 0)
            begin
                pause = $urandom_range(0, 14);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        pbc_pkg::pbc_item_t w;
        logic [31:0] lo;
        int words;
        int reads;
        clear_tally();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_regs(32'h0, 32'hFFFF_FFFF, 8'h0, 7'h0);
        @(negedge clk);

        // each drop condition, both letter cases, field extremes
        w = read_of(4'd0, CH_A);
        w.map_quality = 8'd1;
        w.quality_char = 7'd34;
        add_word(w);
        w = read_of(4'd0, CH_A);
        w.map_quality = 8'd0;
        add_word(w);
        w = read_of(4'd0, CH_A);
        w.quality_char = 7'd33;
        add_word(w);
        w = read_of(4'd1, CH_C);
        w.is_deletion = 1'b1;
        add_word(w);
        for (int f = 8; f < 12; f++)
        begin
            w = read_of(4'd1, CH_G);
            w.align_flags[f] = 1'b1;
            add_word(w);
        end
        w = read_of(4'd1, CH_T);
        w.sample_known = 1'b0;
        add_word(w);
        add_word(read_of(4'd2, CH_N));
        add_word(read_of(4'd15, CH_LC));
        add_word(read_of(4'd15, CH_LG));
        add_word(read_of(4'd15, CH_LT));
        w = read_of(4'd15, CH_LA);
        w.align_flags = 16'hF1FF;
        w.map_quality = 8'hFF;
        w.quality_char = 7'h7F;
        add_word(w);
        w = '1;
        w.func = FUNC_READ;
        add_word(w);
        add_word(end_of(32'h0, CH_LA));
        add_word(end_of(32'hFFFF_FFFF, CH_G));
        add_word(end_of(32'd5, CH_N));
        add_word(read_of(4'd3, CH_T));
        add_word(end_of(32'hFFFF_FFFE, CH_T));
        drain();

        // region edges; mapping and quality cuts at their top
        write_regs(32'd100, 32'd200, 8'hFF, 7'h7F);
        @(negedge clk);
        w = read_of(4'd0, CH_A);
        w.map_quality = 8'hFF;
        w.quality_char = 7'h7F;
        add_word(w);
        add_word(end_of(32'd99, CH_A));
        add_word(end_of(32'd100, CH_C));
        add_word(end_of(32'd199, CH_G));
        add_word(end_of(32'd200, CH_T));
        drain();

        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0: write_regs(32'h0, 32'hFFFF_FFFF, 8'h0, 7'h0);
                1: write_regs(32'h0, 32'hFFFF_FFFF, 8'd254, 7'd93);
                2:
                begin
                    lo = $urandom;
                    write_regs(lo, lo, 8'($urandom), 7'($urandom_range(0, 93)));
                end
                3: write_regs(32'hFFFF_0000, 32'h0000_FFFF, 8'($urandom), 7'd94);
                4: write_regs(32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'hFF, 7'h0);
                default:
                begin
                    lo = $urandom_range(0, 1000);
                    write_regs(lo, lo + $urandom_range(1, 2000), 8'($urandom_range(0, 200)),
                               7'($urandom_range(0, 93)));
                end
            endcase
            @(negedge clk);
            sender_idles   = $urandom_range(0, 3) != 0;
            receiver_idles = $urandom_range(0, 3) != 0;
            words = 0;
            while (words < 18)
            begin
                reads = $urandom_range(0, 12);
                for (int i = 0; i < reads; i++)
                begin
                    case ($urandom_range(0, 19))
                        0, 1, 2:    add_word(make_read(NOISE));
                        3, 4, 5:    add_word(make_read(BROKEN));
                        default:    add_word(make_read(WELL));
                    endcase
                end
                add_word(make_end($urandom_range(0, 6) != 0));
                words += reads + 1;
            end
            drain();
        end

        // back-to-back reads with no idling, then a site to show the clear
        write_regs(32'h0, 32'hFFFF_FFFF, 8'h0, 7'h0);
        @(negedge clk);
        quiet = 1'b1;
        for (int i = 0; i < 16; i++)
            add_word(read_of(4'd5, CH_LG));
        add_word(read_of(4'd5, CH_A));
        add_word(end_of(32'd1234, CH_C));
        add_word(read_of(4'd5, CH_G));
        add_word(end_of(32'd7, CH_T));
        drain();

        if (errors == 0 && site_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/pbc_pkg.sv
hw/rtl/pbc_ctrl.sv
hw/rtl/pbc_datapath.sv
hw/rtl/pileup_base_counter.sv
test/testbench.sv
